[rtl/svdr_pkg.sv]
// Shared constants, types and helper functions of the split virtqueue driver ring.
package svdr_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned QS_W       = 9;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned LEN_W      = 32;

  localparam logic [CNT_W-1:0] END_MARK = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_LAST = '1;
  localparam logic [QS_W-1:0]  QS_RESET = (RING_DEPTH < 256) ? QS_W'(RING_DEPTH) : QS_W'(256);

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_POLL = 2'd1,
    REQ_FREE = 2'd2,
    REQ_USED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_IGNORED = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_COMPLETE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic issue;
    logic complete;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Next ring slot, kept equal to (count + 1) mod queue size.
  function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] slot,
                                                 input logic [CNT_W-1:0] cnt,
                                                 input logic [QS_W-1:0]  qs);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(slot) + CNT_W'(1);
    if (cnt == CNT_LAST || inc == CNT_W'(qs)) begin
      return '0;
    end
    return inc[IDX_W-1:0];
  endfunction

  // Link value of a descriptor that has not been written since initialization.
  function automatic logic [CNT_W-1:0] link_init(input logic [IDX_W-1:0] idx,
                                                 input logic [QS_W-1:0]  qs);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    if (inc < CNT_W'(qs)) begin
      return inc;
    end
    return END_MARK;
  endfunction

endpackage

[rtl/svdr_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
module svdr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output svdr_pkg::cmd_t    cmd_o,
  input  svdr_pkg::dp_stat_t stat_i
);

  svdr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svdr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      svdr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = svdr_pkg::S_ISSUE;
        end
      end
      svdr_pkg::S_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = svdr_pkg::S_COMPLETE;
      end
      svdr_pkg::S_COMPLETE: begin
        cmd_o.complete = 1'b1;
        state_d        = svdr_pkg::S_EMIT;
      end
      svdr_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = svdr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = svdr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/svdr_datapath.sv]
// Datapath with descriptor table, free list, available and used rings, and result register.
module svdr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [svdr_pkg::QS_W-1:0]        cfg_wdata_i,
  input  logic [1:0]                       req_type_i,
  input  logic [svdr_pkg::ADDR_W-1:0]      buffer_addr_i,
  input  logic [svdr_pkg::LEN_W-1:0]       buffer_len_i,
  input  logic [svdr_pkg::CNT_W-1:0]       desc_index_in_i,
  input  logic [svdr_pkg::LEN_W-1:0]       used_len_in_i,
  input  svdr_pkg::cmd_t                   cmd_i,
  output svdr_pkg::dp_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [svdr_pkg::CNT_W-1:0]       desc_index_o,
  output logic [svdr_pkg::LEN_W-1:0]       used_len_o,
  output logic [svdr_pkg::CNT_W-1:0]       avail_index_o
);

  localparam int unsigned IDX_W  = svdr_pkg::IDX_W;
  localparam int unsigned CNT_W  = svdr_pkg::CNT_W;
  localparam int unsigned QS_W   = svdr_pkg::QS_W;
  localparam int unsigned ADDR_W = svdr_pkg::ADDR_W;
  localparam int unsigned LEN_W  = svdr_pkg::LEN_W;
  localparam int unsigned DEPTH  = svdr_pkg::RING_DEPTH;

  // Memories.
  logic [CNT_W-1:0]  link_mem      [DEPTH];
  logic [ADDR_W-1:0] desc_addr_mem [DEPTH];
  logic [LEN_W-1:0]  desc_len_mem  [DEPTH];
  logic [CNT_W-1:0]  avail_mem     [DEPTH];
  logic [CNT_W-1:0]  used_id_mem   [DEPTH];
  logic [LEN_W-1:0]  used_len_mem  [DEPTH];
  logic [DEPTH-1:0]  link_vld_q;

  // Queue state.
  logic [QS_W-1:0]  qs_q;
  logic [CNT_W-1:0] head_q, free_cnt_q, avail_cnt_q, used_cnt_q, seen_cnt_q;
  logic [IDX_W-1:0] avail_slot_q, used_slot_q, seen_slot_q;

  // Latched request.
  svdr_pkg::req_e    req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  blen_q;
  logic [CNT_W-1:0]  idx_in_q;
  logic [LEN_W-1:0]  ulen_in_q;

  // Registered read data.
  logic [CNT_W-1:0] link_rd_q;
  logic             link_vld_rd_q;
  logic [CNT_W-1:0] used_id_rd_q;
  logic [LEN_W-1:0] used_len_rd_q;

  // Result and output registers.
  svdr_pkg::stat_e  res_status_q, res_status_d;
  logic [CNT_W-1:0] res_dix_q, res_dix_d;
  logic [LEN_W-1:0] res_ulen_q, res_ulen_d;
  logic [CNT_W-1:0] res_avail_q, res_avail_d;
  logic             out_vld_q;
  svdr_pkg::stat_e  out_status_q;
  logic [CNT_W-1:0] out_dix_q, out_avail_q;
  logic [LEN_W-1:0] out_ulen_q;

  logic             cfg_load;
  logic             add_ok, poll_ok, free_ok;
  logic             do_add, do_poll, do_free, do_used;
  logic [IDX_W-1:0] head_idx, free_idx;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [CNT_W-1:0] link_wdata;
  logic [CNT_W-1:0] pop_next;

  assign cfg_load = cfg_we_i && (cfg_wdata_i != '0) && (32'(cfg_wdata_i) <= DEPTH);

  assign head_idx = head_q[IDX_W-1:0];
  assign free_idx = idx_in_q[IDX_W-1:0];
  assign add_ok   = (free_cnt_q != '0) && (head_q < CNT_W'(qs_q));
  assign poll_ok  = (used_cnt_q != seen_cnt_q);
  assign free_ok  = (idx_in_q < CNT_W'(qs_q));

  assign do_add  = cmd_i.complete && (req_q == svdr_pkg::REQ_ADD) && add_ok;
  assign do_poll = cmd_i.complete && (req_q == svdr_pkg::REQ_POLL) && poll_ok;
  assign do_free = cmd_i.complete && (req_q == svdr_pkg::REQ_FREE) && free_ok;
  assign do_used = cmd_i.complete && (req_q == svdr_pkg::REQ_USED);

  assign link_we    = do_add || do_free;
  assign link_waddr = do_add ? head_idx : free_idx;
  assign link_wdata = do_add ? svdr_pkg::END_MARK : head_q;
  assign pop_next   = link_vld_rd_q ? link_rd_q : svdr_pkg::link_init(head_idx, qs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= svdr_pkg::req_e'(req_type_i);
      addr_q    <= buffer_addr_i;
      blen_q    <= buffer_len_i;
      idx_in_q  <= desc_index_in_i;
      ulen_in_q <= used_len_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.issue) begin
      link_rd_q     <= link_mem[head_idx];
      link_vld_rd_q <= link_vld_q[head_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_add) begin
      desc_addr_mem[head_idx] <= addr_q;
      desc_len_mem[head_idx]  <= blen_q;
      avail_mem[avail_slot_q] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_used) begin
      used_id_mem[used_slot_q]  <= idx_in_q;
      used_len_mem[used_slot_q] <= ulen_in_q;
    end
    if (cmd_i.issue) begin
      used_id_rd_q  <= used_id_mem[seen_slot_q];
      used_len_rd_q <= used_len_mem[seen_slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (cfg_load) begin
      link_vld_q <= '0;
    end else if (link_we) begin
      link_vld_q[link_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q         <= svdr_pkg::QS_RESET;
      head_q       <= '0;
      free_cnt_q   <= CNT_W'(svdr_pkg::QS_RESET);
      avail_cnt_q  <= '0;
      used_cnt_q   <= '0;
      seen_cnt_q   <= '0;
      avail_slot_q <= '0;
      used_slot_q  <= '0;
      seen_slot_q  <= '0;
    end else if (cfg_load) begin
      qs_q         <= cfg_wdata_i;
      head_q       <= '0;
      free_cnt_q   <= CNT_W'(cfg_wdata_i);
      avail_cnt_q  <= '0;
      used_cnt_q   <= '0;
      seen_cnt_q   <= '0;
      avail_slot_q <= '0;
      used_slot_q  <= '0;
      seen_slot_q  <= '0;
    end else begin
      if (do_add) begin
        head_q       <= pop_next;
        free_cnt_q   <= free_cnt_q - CNT_W'(1);
        avail_cnt_q  <= avail_cnt_q + CNT_W'(1);
        avail_slot_q <= svdr_pkg::slot_next(avail_slot_q, avail_cnt_q, qs_q);
      end
      if (do_free) begin
        head_q     <= idx_in_q;
        free_cnt_q <= free_cnt_q + CNT_W'(1);
      end
      if (do_poll) begin
        seen_cnt_q  <= seen_cnt_q + CNT_W'(1);
        seen_slot_q <= svdr_pkg::slot_next(seen_slot_q, seen_cnt_q, qs_q);
      end
      if (do_used) begin
        used_cnt_q  <= used_cnt_q + CNT_W'(1);
        used_slot_q <= svdr_pkg::slot_next(used_slot_q, used_cnt_q, qs_q);
      end
    end
  end

  always_comb begin
    res_status_d = svdr_pkg::STAT_OK;
    res_dix_d    = '0;
    res_ulen_d   = '0;
    res_avail_d  = avail_cnt_q;
    unique case (req_q)
      svdr_pkg::REQ_ADD: begin
        if (add_ok) begin
          res_dix_d   = head_q;
          res_avail_d = avail_cnt_q + CNT_W'(1);
        end else begin
          res_status_d = svdr_pkg::STAT_BUSY;
        end
      end
      svdr_pkg::REQ_POLL: begin
        if (poll_ok) begin
          res_dix_d  = used_id_rd_q;
          res_ulen_d = used_len_rd_q;
        end else begin
          res_status_d = svdr_pkg::STAT_BUSY;
        end
      end
      svdr_pkg::REQ_FREE: begin
        if (!free_ok) begin
          res_status_d = svdr_pkg::STAT_IGNORED;
        end
      end
      svdr_pkg::REQ_USED: begin
        res_status_d = svdr_pkg::STAT_OK;
      end
      default: begin
        res_status_d = svdr_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.complete) begin
      res_status_q <= res_status_d;
      res_dix_q    <= res_dix_d;
      res_ulen_q   <= res_ulen_d;
      res_avail_q  <= res_avail_d;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_dix_q    <= res_dix_q;
      out_ulen_q   <= res_ulen_q;
      out_avail_q  <= res_avail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign desc_index_o    = out_dix_q;
  assign used_len_o      = out_ulen_q;
  assign avail_index_o   = out_avail_q;

endmodule

[rtl/split_virtqueue_driver_ring.sv]
// Top level of the split virtqueue driver ring: controller and datapath.
//
// Each request (add, poll, free, or device used write) is handled as one
// transaction in four steps: capture at acceptance, ring memory read,
// commit, and load of the output register; the load step waits while the
// output register holds a result not yet taken. A new request is accepted
// only after the previous one has loaded its result. The single-port ring
// and link memories with registered reads set this sequence. A new request
// is accepted while the previous result still waits in the output register;
// the load of its own result then waits until that register is free. A legal
// queue size write re-initializes the queue: the free list is held by
// per-entry valid bits that are cleared at once, so no clearing pass is
// needed after reset or reconfiguration.
module split_virtqueue_driver_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [svdr_pkg::QS_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [svdr_pkg::ADDR_W-1:0]  buffer_addr_i,
  input  logic [svdr_pkg::LEN_W-1:0]   buffer_len_i,
  input  logic [svdr_pkg::CNT_W-1:0]   desc_index_in_i,
  input  logic [svdr_pkg::LEN_W-1:0]   used_len_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [svdr_pkg::CNT_W-1:0]   desc_index_o,
  output logic [svdr_pkg::LEN_W-1:0]   used_len_o,
  output logic [svdr_pkg::CNT_W-1:0]   avail_index_o
);

  svdr_pkg::cmd_t     cmd;
  svdr_pkg::dp_stat_t dp_stat;

  svdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (dp_stat)
  );

  svdr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .buffer_addr_i   (buffer_addr_i),
    .buffer_len_i    (buffer_len_i),
    .desc_index_in_i (desc_index_in_i),
    .used_len_in_i   (used_len_in_i),
    .cmd_i           (cmd),
    .stat_o          (dp_stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .desc_index_o    (desc_index_o),
    .used_len_o      (used_len_o),
    .avail_index_o   (avail_index_o)
  );

endmodule

[verif/split_virtqueue_driver_ring_test.sv]
// Self-checking testbench for the split virtqueue driver ring with its own ring predictor.
`timescale 1ns / 100ps

module split_virtqueue_driver_ring_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RING_DEPTH  = svdr_pkg::RING_DEPTH;
  localparam int unsigned QS_W        = svdr_pkg::QS_W;
  localparam int unsigned CNT_W       = svdr_pkg::CNT_W;
  localparam int unsigned ADDR_W      = svdr_pkg::ADDR_W;
  localparam int unsigned LEN_W       = svdr_pkg::LEN_W;

  typedef struct packed {
    svdr_pkg::req_e    kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  blen;
    logic [CNT_W-1:0]  idx;
    logic [LEN_W-1:0]  ulen;
  } ring_req_t;

  typedef struct packed {
    svdr_pkg::stat_e  status;
    logic [CNT_W-1:0] desc;
    logic [LEN_W-1:0] ulen;
    logic [CNT_W-1:0] avail;
  } ring_resp_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [QS_W-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i = '0;
  logic [ADDR_W-1:0] buffer_addr_i = '0;
  logic [LEN_W-1:0]  buffer_len_i = '0;
  logic [CNT_W-1:0]  desc_index_in_i = '0;
  logic [LEN_W-1:0]  used_len_in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        status_o;
  logic [CNT_W-1:0]  desc_index_o;
  logic [LEN_W-1:0]  used_len_o;
  logic [CNT_W-1:0]  avail_index_o;

  split_virtqueue_driver_ring dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .buffer_addr_i   (buffer_addr_i),
    .buffer_len_i    (buffer_len_i),
    .desc_index_in_i (desc_index_in_i),
    .used_len_in_i   (used_len_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .desc_index_o    (desc_index_o),
    .used_len_o      (used_len_o),
    .avail_index_o   (avail_index_o)
  );

  // Predicted state of the descriptor table and both rings.
  logic [QS_W-1:0]  ring_qs;
  logic [CNT_W-1:0] free_link [RING_DEPTH];
  logic [CNT_W-1:0] used_id_ring [RING_DEPTH];
  logic [LEN_W-1:0] used_len_ring [RING_DEPTH];
  logic [CNT_W-1:0] avail_cnt;
  logic [CNT_W-1:0] used_cnt;
  logic [CNT_W-1:0] seen_cnt;
  logic [CNT_W-1:0] pred_head;
  logic [CNT_W-1:0] free_cnt;

  // Stimulus-side view of descriptor ownership for well-formed traffic.
  int unsigned shadow_qs;
  int          spare_descs[$];
  int          posted_descs[$];
  int          used_descs[$];
  int          reaped_descs[$];

  ring_req_t  request_backlog[$];
  ring_resp_t awaited_results[$];
  ring_req_t  staged_req;
  ring_resp_t oldest_due;

  int          burst_left = 1;
  int          gap_left = 0;
  int          pace_mode = 0;
  int          pace_left = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned ok_seen = 0;
  int unsigned busy_seen = 0;
  int unsigned ignored_seen = 0;
  int unsigned sizes_used = 1;

  function automatic void ring_reinit(int unsigned size);
    ring_qs = QS_W'(size);
    for (int i = 0; i < RING_DEPTH; i++) begin
      free_link[i] = (i + 1 < size) ? CNT_W'(i + 1) : '0;
      used_id_ring[i] = '0;
      used_len_ring[i] = '0;
    end
    free_link[size - 1] = svdr_pkg::END_MARK;
    avail_cnt = '0;
    used_cnt = '0;
    seen_cnt = '0;
    pred_head = '0;
    free_cnt = CNT_W'(size);
  endfunction

  function automatic ring_resp_t ring_apply(ring_req_t r);
    ring_resp_t  res;
    int unsigned slot;
    int unsigned d;
    res = '0;
    res.status = svdr_pkg::STAT_OK;
    case (r.kind)
      svdr_pkg::REQ_ADD: begin
        if (free_cnt == 0 || pred_head >= CNT_W'(ring_qs)) begin
          res.status = svdr_pkg::STAT_BUSY;
        end else begin
          d = pred_head;
          pred_head = free_link[d];
          free_cnt = free_cnt - 1'b1;
          free_link[d] = svdr_pkg::END_MARK;
          avail_cnt = avail_cnt + 1'b1;
          res.desc = CNT_W'(d);
        end
      end
      svdr_pkg::REQ_POLL: begin
        if (used_cnt == seen_cnt) begin
          res.status = svdr_pkg::STAT_BUSY;
        end else begin
          slot = int'(seen_cnt) % int'(ring_qs);
          res.desc = used_id_ring[slot];
          res.ulen = used_len_ring[slot];
          seen_cnt = seen_cnt + 1'b1;
        end
      end
      svdr_pkg::REQ_FREE: begin
        if (r.idx >= CNT_W'(ring_qs)) begin
          res.status = svdr_pkg::STAT_IGNORED;
        end else begin
          free_link[r.idx] = pred_head;
          pred_head = r.idx;
          free_cnt = free_cnt + 1'b1;
        end
      end
      default: begin
        slot = int'(used_cnt) % int'(ring_qs);
        used_id_ring[slot] = r.idx;
        used_len_ring[slot] = r.ulen;
        used_cnt = used_cnt + 1'b1;
      end
    endcase
    res.avail = avail_cnt;
    return res;
  endfunction

  function automatic void shadow_reset(int unsigned size);
    shadow_qs = size;
    spare_descs.delete();
    posted_descs.delete();
    used_descs.delete();
    reaped_descs.delete();
    for (int i = 0; i < size; i++) begin
      spare_descs.push_back(i);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_req(svdr_pkg::req_e k, logic [ADDR_W-1:0] a,
                                    logic [LEN_W-1:0] l, logic [CNT_W-1:0] i,
                                    logic [LEN_W-1:0] u);
    ring_req_t r;
    r.kind = k;
    r.addr = a;
    r.blen = l;
    r.idx = i;
    r.ulen = u;
    request_backlog.push_back(r);
  endfunction

  function automatic void gen_wellformed(int n);
    int unsigned pick;
    int          j;
    ring_req_t   r;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      r.addr = rand_addr();
      r.blen = $urandom;
      r.idx = CNT_W'($urandom);
      r.ulen = $urandom;
      if (pick < 30) begin
        r.kind = svdr_pkg::REQ_ADD;
        if (spare_descs.size() != 0) begin
          posted_descs.push_back(spare_descs.pop_front());
        end
      end else if (pick < 50 && posted_descs.size() != 0) begin
        r.kind = svdr_pkg::REQ_USED;
        j = $urandom_range(0, posted_descs.size() - 1);
        r.idx = CNT_W'(posted_descs[j]);
        posted_descs.delete(j);
        used_descs.push_back(r.idx);
      end else if (pick < 72) begin
        r.kind = svdr_pkg::REQ_POLL;
        if (used_descs.size() != 0) begin
          reaped_descs.push_back(used_descs.pop_front());
        end
      end else if (pick < 94 && reaped_descs.size() != 0) begin
        r.kind = svdr_pkg::REQ_FREE;
        j = $urandom_range(0, reaped_descs.size() - 1);
        r.idx = CNT_W'(reaped_descs[j]);
        reaped_descs.delete(j);
        spare_descs.push_front(r.idx);
      end else begin
        r.kind = svdr_pkg::REQ_FREE;
        r.idx = CNT_W'($urandom_range(shadow_qs, 65535));
      end
      request_backlog.push_back(r);
    end
  endfunction

  // Unconstrained traffic: double frees, overrun of the used ring, arbitrary ids.
  function automatic void gen_noise(int n);
    ring_req_t r;
    for (int k = 0; k < n; k++) begin
      r.kind = svdr_pkg::req_e'($urandom_range(0, 3));
      r.addr = rand_addr();
      r.blen = $urandom;
      r.ulen = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        r.idx = CNT_W'($urandom);
      end else begin
        r.idx = CNT_W'($urandom_range(0, shadow_qs + 1));
      end
      request_backlog.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic wait_quiet();
    while (request_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_queue_size(logic [QS_W-1:0] v);
    wait_quiet();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (v != 0 && v <= RING_DEPTH) begin
      ring_reinit(v);
      shadow_reset(v);
      sizes_used++;
    end
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(ring_apply(staged_req));
        requests_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          staged_req = request_backlog.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= staged_req.kind;
          buffer_addr_i <= staged_req.addr;
          buffer_len_i <= staged_req.blen;
          desc_index_in_i <= staged_req.idx;
          used_len_in_i <= staged_req.ulen;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, desc_index", desc_index_o, 0);
        end else begin
          oldest_due = awaited_results.pop_front();
          if (status_o !== oldest_due.status) begin
            report_mismatch("status", status_o, oldest_due.status);
          end
          if (desc_index_o !== oldest_due.desc) begin
            report_mismatch("desc_index", desc_index_o, oldest_due.desc);
          end
          if (used_len_o !== oldest_due.ulen) begin
            report_mismatch("used_len", used_len_o, oldest_due.ulen);
          end
          if (avail_index_o !== oldest_due.avail) begin
            report_mismatch("avail_index", avail_index_o, oldest_due.avail);
          end
          case (oldest_due.status)
            svdr_pkg::STAT_OK: ok_seen++;
            svdr_pkg::STAT_BUSY: busy_seen++;
            default: ignored_seen++;
          endcase
        end
      end
      if (pace_left == 0) begin
        pace_mode <= $urandom_range(0, 2);
        pace_left <= $urandom_range(20, 120);
      end else begin
        pace_left <= pace_left - 1;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else begin
        case (pace_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned      sizes[8];
    logic [QS_W-1:0]  bad_sizes[3];
    ring_reinit(svdr_pkg::QS_RESET);
    shadow_reset(svdr_pkg::QS_RESET);
    sizes = '{1, 3, 8, 256, 37, 255, 2, 0};
    sizes[7] = $urandom_range(4, 254);
    bad_sizes = '{9'd0, 9'd257, 9'd511};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty poll, descriptor extremes, used ids at both ends, out-of-range frees.
    queue_req(svdr_pkg::REQ_POLL, '0, '0, '0, '0);
    queue_req(svdr_pkg::REQ_ADD, '0, '0, '1, '1);
    queue_req(svdr_pkg::REQ_ADD, '1, '1, '0, '0);
    queue_req(svdr_pkg::REQ_USED, rand_addr(), $urandom, 16'd0, '1);
    queue_req(svdr_pkg::REQ_USED, rand_addr(), $urandom, 16'hFFFF, '0);
    queue_req(svdr_pkg::REQ_POLL, '1, '1, '1, '1);
    queue_req(svdr_pkg::REQ_POLL, '0, '0, '0, '0);
    queue_req(svdr_pkg::REQ_POLL, '0, '0, '0, '0);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'd256, '0);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'hFFFF, '0);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'd1, '0);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'd0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'd255, '0);

    // A double free on a two-entry queue leaves a count with no list behind it.
    write_queue_size(9'd2);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'd0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_POLL, '0, '0, '0, '0);

    write_queue_size(9'd1);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);
    queue_req(svdr_pkg::REQ_FREE, '0, '0, 16'd0, '0);
    queue_req(svdr_pkg::REQ_ADD, rand_addr(), $urandom, '0, '0);

    for (int k = 0; k < 8; k++) begin
      write_queue_size(QS_W'(sizes[k]));
      gen_wellformed(70);
      if (sizes[k] == 256) begin
        hold_req = 1'b1;
      end
      // An illegal size must leave the queue untouched.
      write_queue_size(bad_sizes[k % 3]);
      gen_wellformed(30);
    end

    write_queue_size(9'd3);
    gen_noise(150);

    wait_quiet();
    $display("Checked %0d results from %0d requests over %0d queue sizes", results_seen,
             requests_taken, sizes_used);
    $display("Outcomes: %0d ok, %0d full or empty, %0d out-of-range frees", ok_seen,
             busy_seen, ignored_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/svdr_pkg.sv
rtl/svdr_ctrl.sv
rtl/svdr_datapath.sv
rtl/split_virtqueue_driver_ring.sv
verif/split_virtqueue_driver_ring_test.sv
